/* hdl/jsu_pkg.sv */
// Shared types, character codes and helpers for the JSON string unescaper.
// No dependencies; imported by every module under hdl/.
package jsu_pkg;

  // Decoder modes
  localparam logic [1:0] MODE_SEEK = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_CLOSED   = 2'd1;
  localparam logic [1:0] ST_NO_QUOTE = 2'd2;
  localparam logic [1:0] ST_OPEN_END = 2'd3;

  // Characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_U     = 8'h75;

  // UTF-8 encoding
  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [5:0]  UTF_MASK6 = 6'h3F;
  localparam logic [15:0] UTF_LIM1  = 16'h0080;
  localparam logic [15:0] UTF_LIM2  = 16'h0800;

  localparam int MAX_RES = 4;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } jsu_res_t;

  // All results caused by one input byte, in order from index 0
  typedef struct packed {
    logic [2:0]             count;
    jsu_res_t [MAX_RES-1:0] res;
  } jsu_bundle_t;

  // Bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

/* hdl/jsu_decode.sv */
// Decoder state and single-pass decode of one text byte into a result bundle.
// Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  input  logic        advance,
  output jsu_bundle_t bundle
);

  logic [1:0]  mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_value, hex_value_next;
  logic        hex_run_open, hex_run_open_next;
  logic [4:0]  dig;
  logic [15:0] code;
  logic [2:0]  n;
  logic        is_ws;

  always_comb begin
    bundle            = '0;
    n                 = 3'd0;
    mode_next         = mode;
    hex_count_next    = hex_count;
    hex_value_next    = hex_value;
    hex_run_open_next = hex_run_open;
    dig               = hex_digit(text_byte);
    code              = 16'd0;
    is_ws = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
            (text_byte == CH_LF) || (text_byte == CH_CR);
    unique case (mode)
      MODE_SEEK: begin
        if (text_byte == CH_QUOTE) begin
          mode_next = MODE_STR;
        end else if (!is_ws) begin
          bundle.res[0] = '{data: 8'h00, status: ST_NO_QUOTE};
          n = 3'd1;
        end
      end
      MODE_STR: begin
        if (text_byte == CH_QUOTE) begin
          bundle.res[0] = '{data: 8'h00, status: ST_CLOSED};
          n = 3'd1;
          mode_next = MODE_SEEK;
        end else if (text_byte == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          bundle.res[0] = '{data: text_byte, status: ST_DATA};
          n = 3'd1;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_STR;
        n = 3'd1;
        unique case (text_byte)
          CH_N:    bundle.res[0] = '{data: CH_LF, status: ST_DATA};
          CH_T:    bundle.res[0] = '{data: CH_TAB, status: ST_DATA};
          CH_R:    bundle.res[0] = '{data: CH_CR, status: ST_DATA};
          CH_B:    bundle.res[0] = '{data: CH_BS, status: ST_DATA};
          CH_F:    bundle.res[0] = '{data: CH_FF, status: ST_DATA};
          CH_U: begin
            n = 3'd0;
            mode_next = MODE_HEX;
            hex_count_next = 2'd0;
            hex_value_next = 16'd0;
            hex_run_open_next = 1'b1;
          end
          default: bundle.res[0] = '{data: text_byte, status: ST_DATA};
        endcase
      end
      MODE_HEX: begin
        // Accumulate only while every character so far was a hex digit
        if (hex_run_open && dig[4]) begin
          hex_value_next = {hex_value[11:0], dig[3:0]};
        end else begin
          hex_run_open_next = 1'b0;
        end
        if (hex_count == 2'd3) begin
          code = hex_value_next;
          if (code < UTF_LIM1) begin
            bundle.res[0] = '{data: code[7:0], status: ST_DATA};
            n = 3'd1;
          end else if (code < UTF_LIM2) begin
            bundle.res[0] = '{data: UTF_LEAD2 | {3'b000, code[10:6]}, status: ST_DATA};
            bundle.res[1] = '{data: UTF_CONT | {2'b00, code[5:0] & UTF_MASK6},
                              status: ST_DATA};
            n = 3'd2;
          end else begin
            bundle.res[0] = '{data: UTF_LEAD3 | {4'b0000, code[15:12]}, status: ST_DATA};
            bundle.res[1] = '{data: UTF_CONT | {2'b00, code[11:6]}, status: ST_DATA};
            bundle.res[2] = '{data: UTF_CONT | {2'b00, code[5:0] & UTF_MASK6},
                              status: ST_DATA};
            n = 3'd3;
          end
          hex_count_next    = 2'd0;
          hex_value_next    = 16'd0;
          hex_run_open_next = 1'b1;
          mode_next         = MODE_STR;
        end else begin
          hex_count_next = hex_count + 2'd1;
        end
      end
      default: ;
    endcase
    // Text ended inside a string: append the error and drop back to reset state
    if (end_of_text && mode_next != MODE_SEEK) begin
      bundle.res[n[1:0]] = '{data: 8'h00, status: ST_OPEN_END};
      n = n + 3'd1;
      mode_next         = MODE_SEEK;
      hex_count_next    = 2'd0;
      hex_value_next    = 16'd0;
      hex_run_open_next = 1'b1;
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_SEEK;
      hex_count    <= 2'd0;
      hex_value    <= 16'd0;
      hex_run_open <= 1'b1;
    end else if (advance) begin
      mode         <= mode_next;
      hex_count    <= hex_count_next;
      hex_value    <= hex_value_next;
      hex_run_open <= hex_run_open_next;
    end
  end

  a_hex_count_idle: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_HEX |-> hex_count == 2'd0)
    else $error("hex count left over outside a \\u escape");

  a_hex_value_idle: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_HEX |-> hex_value == 16'd0 && hex_run_open)
    else $error("hex accumulator not cleared outside a \\u escape");

  a_end_seeks: assert property (@(posedge clk) disable iff (rst)
    advance && end_of_text |=> mode == MODE_SEEK)
    else $error("decoder not seeking after end of text");

endmodule

/* hdl/jsu_out_buf.sv */
// Result register: holds one bundle and hands its results out one per transfer.
// Depends on jsu_pkg.
module jsu_out_buf import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  jsu_bundle_t bundle,
  input  logic        load,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tlast
);

  logic                   valid;
  logic [1:0]             idx;
  logic [2:0]             count;
  jsu_res_t [MAX_RES-1:0] res;
  logic                   at_last;

  assign at_last  = ({1'b0, idx} == count - 3'd1);
  assign free     = !valid || (m_tready && at_last);
  assign m_tvalid = valid;
  assign m_tdata  = {6'd0, res[idx].status, res[idx].data};
  assign m_tlast  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
      count <= 3'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
      count <= bundle.count;
    end else if (valid && m_tready) begin
      if (at_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= bundle.res;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> count != 3'd0 && count <= 3'd4)
    else $error("result buffer holds an empty or oversized bundle");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> {1'b0, idx} < count)
    else $error("result index past end of bundle");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free && bundle.count != 3'd0)
    else $error("bundle loaded over unfinished results");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !m_tready |=> valid && $stable(idx))
    else $error("result index moved while stalled");

endmodule

/* hdl/json_string_unescaper_unit.sv */
// Top level of the JSON string unescaper: input register, decoder, result register.
// Depends on jsu_pkg, jsu_decode and jsu_out_buf.
//
// Feed JSON text one byte per transfer on the s_ side, with s_tlast on the last
// byte of the text. Whitespace between strings is skipped, a stray byte outside a
// string gives a "missing opening quote" result, string bytes come out decoded
// (escapes resolved, \uXXXX sent as 1 to 3 UTF-8 bytes), a closing quote gives a
// "string closed" result, and text that ends inside a string gives a final
// "text ended inside string" result. Every result carries m_tlast on the last
// one caused by its input byte; bytes that cause nothing produce no transfer.
// Throughput is one input byte per cycle: each byte is decoded in one pass
// between the input register and the result register. A held byte that causes
// results waits while the result register still has results not yet taken:
// those leave one per cycle while m_tready is high (up to four for a \u escape
// ending the text). Bytes that cause nothing never wait.
module json_string_unescaper_unit import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] status, [15:10] zero
  output logic        m_tlast    // run_last
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;
  logic        buf_free;
  logic        buf_load;
  jsu_bundle_t bundle;

  // Advance the held byte when its results fit: none at all, or a free buffer
  assign advance  = in_valid && (bundle.count == 3'd0 || buf_free);
  assign buf_load = advance && bundle.count != 3'd0;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload: capture on every input transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  jsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .text_byte   (in_byte),
    .end_of_text (in_last),
    .advance     (advance),
    .bundle      (bundle)
  );

  jsu_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .bundle   (bundle),
    .load     (buf_load),
    .free     (buf_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* sim/tb_json_string_unescaper_unit.sv */
// Self-checking bench for json_string_unescaper_unit: a table of directed bytes and
// then random JSON texts, scored against an in-bench model of the unescaper.
// Depends on jsu_pkg (modes, status codes, character and UTF-8 constants).
`timescale 1ns / 100ps

module tb_json_string_unescaper_unit;
  import jsu_pkg::*;

  localparam int LIMIT_CYCLES = 60000;
  localparam int RANDOM_BYTES = 200;
  localparam int DRAIN_BYTES  = 40;   // tail of the run with no idling at all
  localparam int DIR_ROWS     = 26;

  // One decoded result as it should leave the m_ side
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } unesc_out_t;

  // How a directed row is scored: by the model, by a value typed in the table, or as owing no result
  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_ONE} row_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    row_kind_t  kind;
    logic [7:0] t_data;
    logic [1:0] t_status;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] text_byte
  logic        s_tlast = 1'b0;    // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [15:0] m_tdata;           // [7:0] data_byte, [9:8] status, [15:10] zero
  logic        m_tlast;           // run_last

  // Model state, mirrors the decoder
  logic [1:0]  model_mode  = MODE_SEEK;
  logic [1:0]  model_hcnt  = 2'd0;
  logic [15:0] model_hval  = 16'h0000;
  logic        model_hopen = 1'b1;

  unesc_out_t  step_q[$];       // results caused by the byte just decoded
  unesc_out_t  unescaped_q[$];  // results still owed by the block
  unesc_out_t  want;
  logic [7:0]  txt[$];          // JSON text under construction
  logic [7:0]  text_ch[$];
  logic        text_eot[$];
  dir_row_t    dir_rows [DIR_ROWS];

  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_texts = 0;
  int n_multi = 0;
  int n_open_end = 0;
  logic drain_phase = 1'b0;

  json_string_unescaper_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Model of the unescaper. Fills step_q with the results one byte causes.
  // ---------------------------------------------------------------------------
  function automatic void emit(input logic [7:0] data, input logic [1:0] status);
    unesc_out_t r;
    r.data = data;
    r.status = status;
    r.last = 1'b0;
    step_q = {step_q, r};
  endfunction

  function automatic void clear_hex();
    model_hcnt = 2'd0;
    model_hval = 16'h0000;
    model_hopen = 1'b1;
  endfunction

  function automatic void unescape_byte(input logic [7:0] c, input logic eot);
    logic       is_hex;
    logic [7:0] off;
    logic [15:0] code;
    step_q.delete();
    // Classify c as a hex digit and get its value from the offset of its range
    is_hex = 1'b1;
    if (c >= "0" && c <= "9") off = c - 8'h30;
    else if (c >= "a" && c <= "f") off = c - 8'h57;
    else if (c >= "A" && c <= "F") off = c - 8'h37;
    else begin
      is_hex = 1'b0;
      off = 8'h00;
    end

    case (model_mode)
      MODE_SEEK: begin
        if (c == CH_QUOTE) model_mode = MODE_STR;
        else if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR))
          emit(8'h00, ST_NO_QUOTE);
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          emit(8'h00, ST_CLOSED);
          model_mode = MODE_SEEK;
        end else if (c == CH_BSLASH) begin
          model_mode = MODE_ESC;
        end else begin
          emit(c, ST_DATA);
        end
      end
      MODE_ESC: begin
        model_mode = MODE_STR;
        case (c)
          CH_N:    emit(CH_LF, ST_DATA);
          CH_T:    emit(CH_TAB, ST_DATA);
          CH_R:    emit(CH_CR, ST_DATA);
          CH_B:    emit(CH_BS, ST_DATA);
          CH_F:    emit(CH_FF, ST_DATA);
          CH_U: begin
            model_mode = MODE_HEX;
            clear_hex();
          end
          default: emit(c, ST_DATA);
        endcase
      end
      default: begin
        // Accumulate only the leading run of hex digits; still consume all four
        if (model_hopen && is_hex) model_hval = {model_hval[11:0], off[3:0]};
        else model_hopen = 1'b0;
        if (model_hcnt == 2'd3) begin
          code = model_hval;
          if (code < UTF_LIM1) begin
            emit(code[7:0], ST_DATA);
          end else if (code < UTF_LIM2) begin
            emit(UTF_LEAD2 | code[13:6], ST_DATA);
            emit(UTF_CONT | {2'b00, code[5:0] & UTF_MASK6}, ST_DATA);
          end else begin
            emit(UTF_LEAD3 | {4'h0, code[15:12]}, ST_DATA);
            emit(UTF_CONT | {2'b00, code[11:6]}, ST_DATA);
            emit(UTF_CONT | {2'b00, code[5:0] & UTF_MASK6}, ST_DATA);
          end
          if (code >= UTF_LIM1) n_multi++;
          clear_hex();
          model_mode = MODE_STR;
        end else begin
          model_hcnt = model_hcnt + 2'd1;
        end
      end
    endcase

    // Text ending anywhere but between strings is flagged and resets all state
    if (eot && model_mode != MODE_SEEK) begin
      emit(8'h00, ST_OPEN_END);
      model_mode = MODE_SEEK;
      clear_hex();
      n_open_end++;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Append a \u escape: mostly four hex digits spanning all UTF-8 lengths,
  // sometimes a mix of digits and arbitrary bytes
  function automatic void push_unicode();
    logic [15:0] v;
    txt = {txt, CH_BSLASH};
    txt = {txt, CH_U};
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 2))
        0:       v = 16'($urandom_range(0, 'h7f));
        1:       v = 16'($urandom_range('h80, 'h7ff));
        default: v = 16'($urandom_range('h800, 'hffff));
      endcase
      for (int k = 3; k >= 0; k--) txt = {txt, hex_char(v[4*k +: 4])};
    end else begin
      for (int k = 0; k < 4; k++)
        txt = {txt, ($urandom_range(0, 1) ? hex_char(4'($urandom_range(0, 15)))
                                          : 8'($urandom_range(0, 255)))};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: optional idle burst, then hold the byte until the transfer
  // ---------------------------------------------------------------------------
  task automatic feed_byte(input logic [7:0] ch, input logic eot, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= ch;
    s_tlast <= eot;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    n_bytes++;
  endtask

  // Receiver: random stall bursts, quiet windows, and no stalls while draining
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= (stall_left == 1);
    end else if (!drain_phase && (cycles / 150) % 3 != 2 && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Scoreboard: every result transfer must match the oldest owed result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (unescaped_q.size() == 0) begin
        $error("result with nothing owed: data_byte %0h status %0d run_last %0b",
               m_tdata[7:0], m_tdata[9:8], m_tlast);
        errors++;
      end else begin
        want = unescaped_q.pop_front();
        if (m_tdata[7:0] !== want.data) begin
          $error("data_byte: expected %0h, got %0h", want.data, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[9:8] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[9:8]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int nstr;
    int nel;
    int end_kind;
    int cut;
    int total;
    unesc_out_t typed;

    // Directed bytes: seeking errors, skipped blanks, byte FF in a string,
    // escapes, \u at the top of the range and with a non-hex first character, a close,
    // a silent end between strings, and an end right after a backslash
    dir_rows = '{
      '{8'h00,     1'b0, ROW_ONE,  8'h00,  ST_NO_QUOTE},
      '{8'hFF,     1'b0, ROW_ONE,  8'h00,  ST_NO_QUOTE},
      '{CH_SPACE,  1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{CH_TAB,    1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{CH_QUOTE,  1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{8'hFF,     1'b0, ROW_ONE,  8'hFF,  ST_DATA},
      '{CH_BSLASH, 1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{CH_N,      1'b0, ROW_ONE,  CH_LF,  ST_DATA},
      '{CH_BSLASH, 1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{CH_F,      1'b0, ROW_PRED, 8'h00,  ST_DATA},
      '{CH_BSLASH, 1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{CH_U,      1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{"F",       1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{"f",       1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{"F",       1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{"f",       1'b0, ROW_PRED, 8'h00,  ST_DATA},
      '{CH_BSLASH, 1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{CH_U,      1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{"g",       1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{"1",       1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{"2",       1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{"3",       1'b0, ROW_ONE,  8'h00,  ST_DATA},
      '{CH_QUOTE,  1'b0, ROW_ONE,  8'h00,  ST_CLOSED},
      '{CH_CR,     1'b1, ROW_NONE, 8'h00,  ST_DATA},
      '{CH_QUOTE,  1'b0, ROW_NONE, 8'h00,  ST_DATA},
      '{CH_BSLASH, 1'b1, ROW_ONE,  8'h00,  ST_OPEN_END}
    };

    // Build random texts: blanks, occasional stray bytes, then one or two strings
    // with plain bytes, escapes and \u codes; some texts end inside a string
    while (text_ch.size() < RANDOM_BYTES) begin
      txt.delete();
      repeat ($urandom_range(0, 2)) txt = {txt, blank_char()};
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) txt = {txt, 8'($urandom_range(0, 255))};
      nstr = $urandom_range(1, 2);
      end_kind = $urandom_range(0, 5);
      for (int s = 0; s < nstr; s++) begin
        txt = {txt, CH_QUOTE};
        nel = $urandom_range(0, 6);
        for (int e = 0; e < nel; e++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              cut = $urandom_range(0, 255);
              // keep plain bytes plain so the string does not end early
              txt = {txt, ((cut == CH_QUOTE || cut == CH_BSLASH) ? 8'h61 : 8'(cut))};
            end
            5, 6: begin
              txt = {txt, CH_BSLASH};
              case ($urandom_range(0, 6))
                0:       txt = {txt, CH_N};
                1:       txt = {txt, CH_T};
                2:       txt = {txt, CH_R};
                3:       txt = {txt, CH_B};
                4:       txt = {txt, CH_F};
                5:       txt = {txt, ($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH)};
                default: txt = {txt, 8'($urandom_range(0, 255))};
              endcase
            end
            default: push_unicode();
          endcase
        end
        if (s == nstr - 1 && end_kind == 5) begin
          // end the text on the last \u character: up to four results at once
          push_unicode();
        end else begin
          txt = {txt, CH_QUOTE};
          repeat ($urandom_range(0, 1)) txt = {txt, blank_char()};
        end
      end
      if (end_kind == 4) begin
        cut = $urandom_range(1, txt.size());
        while (txt.size() > cut) void'(txt.pop_back());
      end
      foreach (txt[k]) begin
        text_ch = {text_ch, txt[k]};
        text_eot = {text_eot, (k == txt.size() - 1)};
      end
      n_texts++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      feed_byte(dir_rows[r].ch, dir_rows[r].eot, 1'b1);
      unescape_byte(dir_rows[r].ch, dir_rows[r].eot);
      if (dir_rows[r].kind == ROW_PRED) begin
        foreach (step_q[k]) unescaped_q = {unescaped_q, step_q[k]};
      end else if (dir_rows[r].kind == ROW_ONE) begin
        typed.data = dir_rows[r].t_data;
        typed.status = dir_rows[r].t_status;
        typed.last = 1'b1;
        unescaped_q = {unescaped_q, typed};
      end
    end

    // Hold the sender until the block has delivered everything owed
    s_tvalid <= 1'b0;
    do @(posedge clk); while (unescaped_q.size() != 0);

    // Random texts; idle in windows, then drain the tail with no gaps
    total = text_ch.size();
    for (int i = 0; i < total; i++) begin
      if (i == total - DRAIN_BYTES) drain_phase <= 1'b1;
      feed_byte(text_ch[i], text_eot[i], i < total - DRAIN_BYTES && (i / 30) % 3 != 2);
      unescape_byte(text_ch[i], text_eot[i]);
      foreach (step_q[k]) unescaped_q = {unescaped_q, step_q[k]};
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (unescaped_q.size() != 0);
    repeat (8) @(posedge clk);

    $display("Covered %0d text bytes (%0d random texts), %0d results checked,",
             n_bytes, n_texts, n_results);
    $display("  %0d multi-byte code points, %0d texts ending inside a string.",
             n_multi, n_open_end);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
